// ===== rtl/cft_pkg.sv =====
// ----------------------------------------------------------------------------
// cft_pkg
// Shared constants, register codes and the sine table generator for the
// cycloid foot trajectory core.
// ----------------------------------------------------------------------------
package cft_pkg;

    // default sizes
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int POSITION_WIDTH_DEF  = 16;

    // pipeline depth, accept to result
    localparam int PIPE_STAGES = 6;

    // configuration port
    localparam int CFG_ADDR_W  = 6;
    localparam int CFG_IDX_LSB = 3;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [2:0] {
        REG_STEP_HALF = 3'd0,
        REG_LIFT      = 3'd1,
        REG_LAT_OFF   = 3'd2,
        REG_LEG_DIR   = 3'd3,
        REG_CG_SHIFT  = 3'd4
    } cfg_reg_t;

    // per-leg direction codes
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BACK = 2'd2;

    // fixed-point widths and constants
    localparam int PHASE_W   = 17;
    localparam int SIN_W     = 17;
    localparam int S_PROD_W  = 33;
    localparam int F32_W     = 35;
    localparam int F24_W     = 27;
    localparam int CORD_W    = 17;
    localparam int CG_W      = 16;
    localparam int ROUND_Q24 = 1 << 23;
    localparam int ROUND_Q16 = 1 << 15;

    localparam logic [PHASE_W-1:0] PHASE_ONE = 17'h10000;
    localparam logic [CORD_W-1:0]  ONE_Q15   = 17'h08000;
    localparam logic [15:0]        HALF_Q16  = 16'h8000;
    localparam logic signed [15:0] INV_TWO_PI_Q17 = 16'sd20861;

    // sine table generation, evaluated at elaboration only
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned FACT_STEP [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    // sin(k*pi/(2*2^bits)) in Q15, Taylor series to degree 17 in Q30
    function automatic logic [15:0] sine_entry(input int k, input int bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned quarter;
        longint          sum;
        int              n;
        quarter = 64'd1 << bits;
        x       = (64'(k) * PI_Q30 + quarter) >> (bits + 1);
        x2      = (x * x + (64'd1 << 29)) >> 30;
        term    = x;
        sum     = longint'(x);
        for (n = 0; n < 8; n++)
        begin
            term = ((term * x2) >> 30) / FACT_STEP[n];
            if (!n[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        sum = (sum + 64'sd16384) >>> 15;
        if (sum < 0)
            sum = 0;
        if (sum > 32768)
            sum = 32768;
        return 16'(sum);
    endfunction

endpackage

// ===== rtl/cft_in_if.sv =====
// ----------------------------------------------------------------------------
// cft_in_if
// Leg command channel: leg, gait phase, stance flag, start x, base height.
// ----------------------------------------------------------------------------
interface cft_in_if
    import cft_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
);
    logic                             valid;
    logic                             ready;
    logic [1:0]                       leg;
    logic [PHASE_W-1:0]               phase;
    logic                             in_stance;
    logic signed [POSITION_WIDTH-1:0] start_x;
    logic signed [POSITION_WIDTH-1:0] base_z;

    modport source (
        output valid, leg, phase, in_stance, start_x, base_z,
        input  ready
    );

    modport sink (
        input  valid, leg, phase, in_stance, start_x, base_z,
        output ready
    );
endinterface

// ===== rtl/cft_out_if.sv =====
// ----------------------------------------------------------------------------
// cft_out_if
// Foot target channel: echoed leg and the saturated x, y, z target.
// ----------------------------------------------------------------------------
interface cft_out_if
    import cft_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
);
    logic                             valid;
    logic                             ready;
    logic [1:0]                       leg_out;
    logic signed [POSITION_WIDTH-1:0] foot_x;
    logic signed [POSITION_WIDTH-1:0] foot_y;
    logic signed [POSITION_WIDTH-1:0] foot_z;

    modport source (
        output valid, leg_out, foot_x, foot_y, foot_z,
        input  ready
    );

    modport sink (
        input  valid, leg_out, foot_x, foot_y, foot_z,
        output ready
    );
endinterface

// ===== rtl/cft_apb_regs.sv =====
// ----------------------------------------------------------------------------
// cft_apb_regs
// APB register file: step half length, lift height, lateral offset,
// leg directions and packed per-leg CG shifts.
// ----------------------------------------------------------------------------
module cft_apb_regs
    import cft_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [CFG_ADDR_W-1:0]            paddr,
    input  logic [CFG_DATA_W-1:0]            pwdata,
    output logic [CFG_DATA_W-1:0]            prdata,
    output logic                             pready,
    output logic [POSITION_WIDTH-2:0]        step_half_length,
    output logic [POSITION_WIDTH-2:0]        lift_height,
    output logic signed [POSITION_WIDTH-1:0] lateral_offset,
    output logic [7:0]                       leg_directions,
    output logic [CFG_DATA_W-1:0]            cg_shifts
);

    logic [POSITION_WIDTH-2:0] step_half_reg, step_half_next;
    logic [POSITION_WIDTH-2:0] lift_reg, lift_next;
    logic [POSITION_WIDTH-1:0] lat_off_reg, lat_off_next;
    logic [7:0]                leg_dir_reg, leg_dir_next;
    logic [CFG_DATA_W-1:0]     cg_reg, cg_next;
    cfg_reg_t                  reg_sel;
    logic                      wr_beat;

    assign reg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:CFG_IDX_LSB]);
    assign wr_beat = psel & penable & pwrite & pready;
    assign pready  = 1'b1;

    always_comb
    begin
        step_half_next = step_half_reg;
        lift_next      = lift_reg;
        lat_off_next   = lat_off_reg;
        leg_dir_next   = leg_dir_reg;
        cg_next        = cg_reg;
        if (wr_beat)
        begin
            case (reg_sel)
                REG_STEP_HALF: step_half_next = pwdata[POSITION_WIDTH-2:0];
                REG_LIFT:      lift_next      = pwdata[POSITION_WIDTH-2:0];
                REG_LAT_OFF:   lat_off_next   = pwdata[POSITION_WIDTH-1:0];
                REG_LEG_DIR:   leg_dir_next   = pwdata[7:0];
                REG_CG_SHIFT:  cg_next        = pwdata;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_half_reg <= '0;
            lift_reg      <= '0;
            lat_off_reg   <= '0;
            leg_dir_reg   <= '0;
            cg_reg        <= '0;
        end
        else
        begin
            step_half_reg <= step_half_next;
            lift_reg      <= lift_next;
            lat_off_reg   <= lat_off_next;
            leg_dir_reg   <= leg_dir_next;
            cg_reg        <= cg_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_STEP_HALF: prdata = CFG_DATA_W'(step_half_reg);
            REG_LIFT:      prdata = CFG_DATA_W'(lift_reg);
            REG_LAT_OFF:   prdata = CFG_DATA_W'(lat_off_reg);
            REG_LEG_DIR:   prdata = CFG_DATA_W'(leg_dir_reg);
            REG_CG_SHIFT:  prdata = cg_reg;
            default:       prdata = '0;
        endcase
    end

    assign step_half_length = step_half_reg;
    assign lift_height      = lift_reg;
    assign lateral_offset   = lat_off_reg;
    assign leg_directions   = leg_dir_reg;
    assign cg_shifts        = cg_reg;

endmodule

// ===== rtl/cft_sine_rom.sv =====
// ----------------------------------------------------------------------------
// cft_sine_rom
// Quarter-wave sine table in Q15 with two registered read ports.
// ----------------------------------------------------------------------------
module cft_sine_rom
    import cft_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [SINE_TABLE_BITS:0] addr_a,
    input  logic [SINE_TABLE_BITS:0] addr_b,
    output logic [15:0]              data_a,
    output logic [15:0]              data_b
);

    localparam int ENTRIES = (1 << SINE_TABLE_BITS) + 1;

    logic [15:0] sine_q15 [ENTRIES];
    logic [15:0] data_a_reg;
    logic [15:0] data_b_reg;

    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_entry
        assign sine_q15[k] = sine_entry(k, SINE_TABLE_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_a_reg <= sine_q15[addr_a];
            data_b_reg <= sine_q15[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

// ===== rtl/cft_pipe.sv =====
// ----------------------------------------------------------------------------
// cft_pipe
// Six-stage trajectory datapath: angle and distance, table read, sine and
// stance products, cycloid fraction and lift product, x product, output.
// ----------------------------------------------------------------------------
module cft_pipe
    import cft_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int POSITION_WIDTH  = POSITION_WIDTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [POSITION_WIDTH-2:0]        step_half_length,
    input  logic [POSITION_WIDTH-2:0]        lift_height,
    input  logic signed [POSITION_WIDTH-1:0] lateral_offset,
    input  logic [7:0]                       leg_directions,
    input  logic [CFG_DATA_W-1:0]            cg_shifts,
    cft_in_if.sink                           leg_cmd,
    cft_out_if.source                        foot_target
);

    localparam int P   = POSITION_WIDTH;
    localparam int B   = SINE_TABLE_BITS;
    localparam int AW  = B + 1;
    localparam int TW  = PHASE_W + B + 3;
    localparam int DW  = ((P > CG_W) ? P : CG_W) + 2;
    localparam int STW = DW + PHASE_W + 1;
    localparam int XPW = DW + F24_W;
    localparam int ZPW = P + 16;
    localparam int XSW = XPW - 24 + 1;
    localparam int XTW = STW - 16 + 1;
    localparam int XFW = (XSW > XTW) ? XSW : XTW;

    localparam logic [P-1:0] POS_MAX = {1'b0, {(P-1){1'b1}}};
    localparam logic [P-1:0] POS_MIN = {1'b1, {(P-1){1'b0}}};

    // ------------------------------------------------------------------
    // stage handshake
    // ------------------------------------------------------------------
    logic [PIPE_STAGES-1:0] valid_reg, valid_next, adv;

    always_comb
    begin
        adv[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] | foot_target.ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--)
            adv[k] = !valid_reg[k] | adv[k+1];
        valid_next[0] = adv[0] ? leg_cmd.valid : valid_reg[0];
        for (int k = 1; k < PIPE_STAGES; k++)
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign leg_cmd.ready = adv[0];

    // ------------------------------------------------------------------
    // stage 1: clamp phase, angle index, per-leg distance, lateral y
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0]   t_cl;
    logic [TW-1:0]        t_scaled, idx_full;
    logic [1:0]           dcode;
    logic signed [CG_W-1:0] cg_leg;
    logic signed [DW-1:0] xf_e, cg_e, xs_e, dist_sw, dist_st, s1_dist_next;
    logic signed [P:0]    y_full;
    logic [P-1:0]         s1_y_next;
    logic                 y_neg;

    assign t_cl     = (leg_cmd.phase > PHASE_ONE) ? PHASE_ONE : leg_cmd.phase;
    assign t_scaled = TW'(t_cl) << (B + 2);
    assign idx_full = (t_scaled + TW'(HALF_Q16)) >> 16;

    assign dcode  = leg_directions[{leg_cmd.leg, 1'b0} +: 2];
    assign cg_leg = cg_shifts[{leg_cmd.leg, 4'b0000} +: CG_W];
    assign xf_e   = {{(DW-P+1){1'b0}}, step_half_length};
    assign cg_e   = {{(DW-CG_W){cg_leg[CG_W-1]}}, cg_leg};
    assign xs_e   = {{(DW-P){leg_cmd.start_x[P-1]}}, leg_cmd.start_x};

    always_comb
    begin
        case (dcode)
            DIR_FWD:
            begin
                dist_sw = xf_e + cg_e - xs_e;
                dist_st = xf_e - cg_e + xs_e;
            end
            DIR_BACK:
            begin
                dist_sw = cg_e - xf_e - xs_e;
                dist_st = xs_e - xf_e - cg_e;
            end
            default:
            begin
                dist_sw = '0;
                dist_st = '0;
            end
        endcase
    end

    assign s1_dist_next = leg_cmd.in_stance ? dist_st : dist_sw;

    // legs 0 and 3 sit on the negative side
    assign y_neg  = (leg_cmd.leg == 2'd0) || (leg_cmd.leg == 2'd3);
    assign y_full = y_neg ? -{lateral_offset[P-1], lateral_offset}
                          : {lateral_offset[P-1], lateral_offset};
    assign s1_y_next = (y_full[P] != y_full[P-1]) ? (y_full[P] ? POS_MIN : POS_MAX)
                                                  : y_full[P-1:0];

    logic [1:0]           s1_leg_reg;
    logic [PHASE_W-1:0]   s1_t_reg;
    logic                 s1_stance_reg;
    logic signed [P-1:0]  s1_xs_reg, s1_base_reg;
    logic signed [DW-1:0] s1_dist_reg;
    logic [P-1:0]         s1_y_reg;
    logic [1:0]           s1_quad_reg;
    logic [B-1:0]         s1_frac_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_leg_reg    <= leg_cmd.leg;
            s1_t_reg      <= t_cl;
            s1_stance_reg <= leg_cmd.in_stance;
            s1_xs_reg     <= leg_cmd.start_x;
            s1_base_reg   <= leg_cmd.base_z;
            s1_dist_reg   <= s1_dist_next;
            s1_y_reg      <= s1_y_next;
            s1_quad_reg   <= idx_full[B+1:B];
            s1_frac_reg   <= idx_full[B-1:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: table read at r and N-r
    // ------------------------------------------------------------------
    logic [AW-1:0] addr_lo, addr_hi;
    logic [15:0]   tab_lo, tab_hi;

    assign addr_lo = {1'b0, s1_frac_reg};
    assign addr_hi = AW'(1 << B) - addr_lo;

    cft_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .clk    (clk),
        .en     (adv[1]),
        .addr_a (addr_lo),
        .addr_b (addr_hi),
        .data_a (tab_lo),
        .data_b (tab_hi)
    );

    logic [1:0]           s2_leg_reg;
    logic [PHASE_W-1:0]   s2_t_reg;
    logic                 s2_stance_reg;
    logic signed [P-1:0]  s2_xs_reg, s2_base_reg;
    logic signed [DW-1:0] s2_dist_reg;
    logic [P-1:0]         s2_y_reg;
    logic [1:0]           s2_quad_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_leg_reg    <= s1_leg_reg;
            s2_t_reg      <= s1_t_reg;
            s2_stance_reg <= s1_stance_reg;
            s2_xs_reg     <= s1_xs_reg;
            s2_base_reg   <= s1_base_reg;
            s2_dist_reg   <= s1_dist_reg;
            s2_y_reg      <= s1_y_reg;
            s2_quad_reg   <= s1_quad_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: sin and cos by quadrant, sine product, stance product
    // ------------------------------------------------------------------
    logic [15:0]                sin_mag, cos_mag;
    logic signed [SIN_W-1:0]    sin_val;
    logic signed [S_PROD_W-1:0] s3_sprod_next;
    logic [CORD_W-1:0]          s3_zc_next;
    logic signed [STW-1:0]      s3_stprod_next;
    logic signed [PHASE_W:0]    t_signed;

    assign sin_mag = s2_quad_reg[0] ? tab_hi : tab_lo;
    assign cos_mag = s2_quad_reg[0] ? tab_lo : tab_hi;
    assign sin_val = s2_quad_reg[1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
    assign s3_sprod_next = sin_val * INV_TWO_PI_Q17;
    // cos is negative in the second and third quadrants
    assign s3_zc_next = (s2_quad_reg[0] ^ s2_quad_reg[1]) ? ONE_Q15 + CORD_W'(cos_mag)
                                                          : ONE_Q15 - CORD_W'(cos_mag);
    assign t_signed       = {1'b0, s2_t_reg};
    assign s3_stprod_next = s2_dist_reg * t_signed;

    logic [1:0]                 s3_leg_reg;
    logic [PHASE_W-1:0]         s3_t_reg;
    logic                       s3_stance_reg;
    logic signed [P-1:0]        s3_xs_reg, s3_base_reg;
    logic signed [DW-1:0]       s3_dist_reg;
    logic [P-1:0]               s3_y_reg;
    logic signed [S_PROD_W-1:0] s3_sprod_reg;
    logic [CORD_W-1:0]          s3_zc_reg;
    logic signed [STW-1:0]      s3_stprod_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_leg_reg    <= s2_leg_reg;
            s3_t_reg      <= s2_t_reg;
            s3_stance_reg <= s2_stance_reg;
            s3_xs_reg     <= s2_xs_reg;
            s3_base_reg   <= s2_base_reg;
            s3_dist_reg   <= s2_dist_reg;
            s3_y_reg      <= s2_y_reg;
            s3_sprod_reg  <= s3_sprod_next;
            s3_zc_reg     <= s3_zc_next;
            s3_stprod_reg <= s3_stprod_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: cycloid fraction (t - sin/2pi) in Q24, lift product
    // ------------------------------------------------------------------
    logic signed [F32_W-1:0] f32, f32_rnd;
    logic signed [F24_W-1:0] s4_f24_next;
    logic [ZPW-1:0]          s4_zprod_next;

    assign f32     = $signed(F32_W'({s3_t_reg, 16'h0000})) - F32_W'(s3_sprod_reg);
    assign f32_rnd = f32 + F32_W'(128);
    assign s4_f24_next   = f32_rnd[F32_W-1:8];
    assign s4_zprod_next = ZPW'(lift_height) * ZPW'(s3_zc_reg);

    logic [1:0]              s4_leg_reg;
    logic                    s4_stance_reg;
    logic signed [P-1:0]     s4_xs_reg, s4_base_reg;
    logic signed [DW-1:0]    s4_dist_reg;
    logic [P-1:0]            s4_y_reg;
    logic signed [F24_W-1:0] s4_f24_reg;
    logic [ZPW-1:0]          s4_zprod_reg;
    logic signed [STW-1:0]   s4_stprod_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s4_leg_reg    <= s3_leg_reg;
            s4_stance_reg <= s3_stance_reg;
            s4_xs_reg     <= s3_xs_reg;
            s4_base_reg   <= s3_base_reg;
            s4_dist_reg   <= s3_dist_reg;
            s4_y_reg      <= s3_y_reg;
            s4_f24_reg    <= s4_f24_next;
            s4_zprod_reg  <= s4_zprod_next;
            s4_stprod_reg <= s3_stprod_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: swing x product, rounded lift
    // ------------------------------------------------------------------
    logic signed [XPW-1:0] s5_xprod_next;
    logic [ZPW-1:0]        zprod_rnd;
    logic [P-2:0]          s5_zadd_next;

    assign s5_xprod_next = s4_dist_reg * s4_f24_reg;
    assign zprod_rnd     = s4_zprod_reg + ZPW'(HALF_Q16);
    assign s5_zadd_next  = zprod_rnd[P+14:16];

    logic [1:0]            s5_leg_reg;
    logic                  s5_stance_reg;
    logic signed [P-1:0]   s5_xs_reg, s5_base_reg;
    logic [P-1:0]          s5_y_reg;
    logic signed [XPW-1:0] s5_xprod_reg;
    logic signed [STW-1:0] s5_stprod_reg;
    logic [P-2:0]          s5_zadd_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s5_leg_reg    <= s4_leg_reg;
            s5_stance_reg <= s4_stance_reg;
            s5_xs_reg     <= s4_xs_reg;
            s5_base_reg   <= s4_base_reg;
            s5_y_reg      <= s4_y_reg;
            s5_xprod_reg  <= s5_xprod_next;
            s5_stprod_reg <= s4_stprod_reg;
            s5_zadd_reg   <= s5_zadd_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: round, add start point, saturate into the output register
    // ------------------------------------------------------------------
    logic signed [XPW-1:0]   xprod_rnd;
    logic signed [XSW-2:0]   x_sw_sh;
    logic signed [XSW-1:0]   x_sw_full;
    logic signed [STW-1:0]   stprod_rnd;
    logic signed [XTW-2:0]   x_st_sh;
    logic signed [XTW-1:0]   x_st_full;
    logic signed [XFW-1:0]   x_full;
    logic [XFW-P:0]          x_top;
    logic signed [P:0]       z_full;
    logic [P-1:0]            out_x_next, out_z_next;

    assign xprod_rnd  = s5_xprod_reg + XPW'(ROUND_Q24);
    assign x_sw_sh    = xprod_rnd[XPW-1:24];
    assign x_sw_full  = XSW'(x_sw_sh) + XSW'(s5_xs_reg);
    assign stprod_rnd = s5_stprod_reg + STW'(ROUND_Q16);
    assign x_st_sh    = stprod_rnd[STW-1:16];
    assign x_st_full  = XTW'(s5_xs_reg) - XTW'(x_st_sh);
    assign x_full     = s5_stance_reg ? XFW'(x_st_full) : XFW'(x_sw_full);

    // in range when the sign bit and all bits above it agree
    assign x_top      = x_full[XFW-1:P-1];
    assign out_x_next = ((&x_top) | ~(|x_top)) ? x_full[P-1:0]
                                               : (x_full[XFW-1] ? POS_MIN : POS_MAX);

    assign z_full = s5_stance_reg ? {s5_base_reg[P-1], s5_base_reg}
                                  : {s5_base_reg[P-1], s5_base_reg} + {2'b00, s5_zadd_reg};
    assign out_z_next = (z_full[P] != z_full[P-1]) ? (z_full[P] ? POS_MIN : POS_MAX)
                                                   : z_full[P-1:0];

    logic [1:0]   out_leg_reg;
    logic [P-1:0] out_x_reg, out_y_reg, out_z_reg;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            out_leg_reg <= s5_leg_reg;
            out_x_reg   <= out_x_next;
            out_y_reg   <= s5_y_reg;
            out_z_reg   <= out_z_next;
        end
    end

    assign foot_target.valid   = valid_reg[PIPE_STAGES-1];
    assign foot_target.leg_out = out_leg_reg;
    assign foot_target.foot_x  = out_x_reg;
    assign foot_target.foot_y  = out_y_reg;
    assign foot_target.foot_z  = out_z_reg;

endmodule

// ===== rtl/cycloid_foot_trajectory_core.sv =====
// ----------------------------------------------------------------------------
// cycloid_foot_trajectory_core
// Foot target generator for a four-legged gait: cycloid swing, linear stance.
// Each accepted leg command beat passes the stage registers in order to its result beat.
// Throughput: one beat per cycle unless the result stalls; a stage advances when the next
// can take its beat. A stall holds the full stages at the end; earlier bubbles fill.
// Reset clears the configuration registers and all stage valid bits.
// The sine table is constant logic, so no start-up pass follows reset.
// ----------------------------------------------------------------------------
module cycloid_foot_trajectory_core
    import cft_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int POSITION_WIDTH  = POSITION_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    cft_in_if.sink                leg_cmd,
    cft_out_if.source             foot_target
);

    logic [POSITION_WIDTH-2:0]        step_half_length;
    logic [POSITION_WIDTH-2:0]        lift_height;
    logic signed [POSITION_WIDTH-1:0] lateral_offset;
    logic [7:0]                       leg_directions;
    logic [CFG_DATA_W-1:0]            cg_shifts;

    cft_apb_regs #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_regs (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .step_half_length (step_half_length),
        .lift_height      (lift_height),
        .lateral_offset   (lateral_offset),
        .leg_directions   (leg_directions),
        .cg_shifts        (cg_shifts)
    );

    cft_pipe #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .POSITION_WIDTH  (POSITION_WIDTH)
    ) u_pipe (
        .clk              (clk),
        .rst_n            (rst_n),
        .step_half_length (step_half_length),
        .lift_height      (lift_height),
        .lateral_offset   (lateral_offset),
        .leg_directions   (leg_directions),
        .cg_shifts        (cg_shifts),
        .leg_cmd          (leg_cmd),
        .foot_target      (foot_target)
    );

    // an output slot that is free or draining must open the input side
    a_ready_when_draining: assert property (@(posedge clk) disable iff (!rst_n)
        (!foot_target.valid || foot_target.ready) |-> leg_cmd.ready)
        else $error("leg command stalled while the output slot is free");

    a_dir_write: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready &&
         cfg_reg_t'(paddr[CFG_ADDR_W-1:CFG_IDX_LSB]) == REG_LEG_DIR)
        |=> leg_directions == $past(pwdata[7:0]))
        else $error("leg direction write not taken");

    a_cg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready &&
         cfg_reg_t'(paddr[CFG_ADDR_W-1:CFG_IDX_LSB]) == REG_CG_SHIFT)
        |=> cg_shifts == $past(pwdata))
        else $error("cg shift write not taken");

endmodule
